FILE: rtl/tssu_pkg.sv
// shared types, constants and arithmetic helpers for the support point search unit
package tssu_pkg;

	// vertex count per query before the index wraps
	localparam int MAX_POINTS = 1024;
	localparam int CNT_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

	// field widths
	localparam int COORD_W = 32;
	localparam int COEF_W  = 16;
	localparam int IDX_W   = 10;
	localparam int DOT_W   = 48;
	localparam int ROW_REG_W = 64;
	localparam int DIR_REG_W = 48;

	// arithmetic widths
	localparam int PROD_W    = COEF_W + COORD_W;
	localparam int ROW_W     = PROD_W + 2;
	localparam int FRAC_DROP = 12;
	localparam int ROWQ_W    = ROW_W - FRAC_DROP;
	localparam int DSUM_W    = PROD_W + 2;

	// decoupling queue
	localparam int QUEUE_DEPTH = 8;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int FRONT_STAGES = 4;
	localparam int FLY_W        = $clog2(FRONT_STAGES + 1);
	localparam int OCC_W        = ((QCNT_W > FLY_W) ? QCNT_W : FLY_W) + 1;

	// configuration port
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_X     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y     = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_Z     = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = CFG_IDX_W'(3);

	// identity transform and +x direction
	localparam logic [ROW_REG_W-1:0] ROW_X_RST = 64'h0000_0000_0000_1000;
	localparam logic [ROW_REG_W-1:0] ROW_Y_RST = 64'h0000_0000_1000_0000;
	localparam logic [ROW_REG_W-1:0] ROW_Z_RST = 64'h0000_1000_0000_0000;
	localparam logic [DIR_REG_W-1:0] DIR_RST   = 48'h0000_0000_1000;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [COEF_W-1:0]  coef_t;
	typedef logic signed [DOT_W-1:0]   dot_t;
	typedef logic signed [PROD_W-1:0]  prod_t;

	// one transformed vertex on its way from front to back
	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		dot_t   dot;
		logic   last;
	} entry_t;

	function automatic prod_t mul_coef(input coef_t a, input coord_t b);
		mul_coef = PROD_W'(a) * PROD_W'(b);
	endfunction

	// clamp a floored row sum to the signed coordinate range
	function automatic coord_t sat_coord(input logic signed [ROWQ_W-1:0] v);
		if (v[ROWQ_W-1:COORD_W-1] == {(ROWQ_W-COORD_W+1){v[COORD_W-1]}}) begin
			sat_coord = v[COORD_W-1:0];
		end else if (v[ROWQ_W-1]) begin
			sat_coord = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			sat_coord = {1'b0, {(COORD_W-1){1'b1}}};
		end
	endfunction

	// clamp a dot sum to the signed 48-bit range
	function automatic dot_t sat_dot(input logic signed [DSUM_W-1:0] v);
		if (v[DSUM_W-1:DOT_W-1] == {(DSUM_W-DOT_W+1){v[DOT_W-1]}}) begin
			sat_dot = v[DOT_W-1:0];
		end else if (v[DSUM_W-1]) begin
			sat_dot = {1'b1, {(DOT_W-1){1'b0}}};
		end else begin
			sat_dot = {1'b0, {(DOT_W-1){1'b1}}};
		end
	endfunction

endpackage

FILE: rtl/tssu_front.sv
// front end: affine transform and dot product pipeline, four stages
module tssu_front import tssu_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  coord_t                        point_x,
	input  coord_t                        point_y,
	input  coord_t                        point_z,
	input  logic                          last_point,
	input  logic [2:0][ROW_REG_W-1:0]     rows,
	input  logic [DIR_REG_W-1:0]          direction,
	output logic                          push,
	output entry_t                        push_entry,
	output logic [FLY_W-1:0]              in_flight
);

	coord_t pt [3];
	logic   valid_s1, valid_s2, valid_s3, valid_s4;
	logic   last_s1, last_s2, last_s3, last_s4;
	prod_t  prod_s1 [3][3];
	coord_t w_s2 [3];
	coord_t w_s3 [3];
	coord_t w_s4 [3];
	prod_t  dprod_s3 [3];
	dot_t   dot_s4;
	logic signed [ROW_W-1:0]  row_acc [3];
	logic signed [DSUM_W-1:0] dot_acc;

	assign pt[0] = point_x;
	assign pt[1] = point_y;
	assign pt[2] = point_z;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			row_acc[r] = ROW_W'(prod_s1[r][0]) + ROW_W'(prod_s1[r][1])
				+ ROW_W'(prod_s1[r][2])
				+ ROW_W'($signed({rows[r][ROW_REG_W-1 -: COEF_W], 16'h0000}));
		end
		dot_acc = DSUM_W'(dprod_s3[0]) + DSUM_W'(dprod_s3[1]) + DSUM_W'(dprod_s3[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		// s1: nine coefficient products
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				prod_s1[r][c] <= mul_coef(coef_t'(rows[r][COEF_W*c +: COEF_W]), pt[c]);
			end
		end
		last_s1 <= last_point;
		// s2: add translation, floor to q16.16, saturate
		for (int r = 0; r < 3; r++) begin
			w_s2[r] <= sat_coord(row_acc[r][ROW_W-1:FRAC_DROP]);
		end
		last_s2 <= last_s1;
		// s3: direction products
		for (int c = 0; c < 3; c++) begin
			dprod_s3[c] <= mul_coef(coef_t'(direction[COEF_W*c +: COEF_W]), w_s2[c]);
			w_s3[c]     <= w_s2[c];
		end
		last_s3 <= last_s2;
		// s4: dot sum and saturate
		dot_s4  <= sat_dot(dot_acc);
		w_s4    <= w_s3;
		last_s4 <= last_s3;
	end

	assign push            = valid_s4;
	assign push_entry.x    = w_s4[0];
	assign push_entry.y    = w_s4[1];
	assign push_entry.z    = w_s4[2];
	assign push_entry.dot  = dot_s4;
	assign push_entry.last = last_s4;

	assign in_flight = FLY_W'(valid_s1) + FLY_W'(valid_s2) + FLY_W'(valid_s3)
		+ FLY_W'(valid_s4);

endmodule

FILE: rtl/tssu_queue.sv
// small queue of transformed vertices between front and back
module tssu_queue import tssu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  entry_t            push_entry,
	input  logic              pop,
	output logic              head_valid,
	output entry_t            head,
	output logic [QCNT_W-1:0] count
);

	entry_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		ptr_next = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	assign head       = mem_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign count      = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> count_q < QCNT_W'(QUEUE_DEPTH))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue read while empty");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with empty count");

endmodule

FILE: rtl/tssu_back.sv
// back end: running best compare, index count and result register
module tssu_back import tssu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  entry_t           head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output coord_t           best_x,
	output coord_t           best_y,
	output coord_t           best_z,
	output logic [IDX_W-1:0] best_index,
	output dot_t             best_dot
);

	logic             have_q;
	logic [CNT_W-1:0] cnt_q;
	coord_t           bx_q, by_q, bz_q;
	dot_t             bdot_q;
	logic [CNT_W-1:0] bidx_q;
	logic             out_valid_q;
	coord_t           ox_q, oy_q, oz_q;
	dot_t             odot_q;
	logic [IDX_W-1:0] oidx_q;

	logic             take;
	coord_t           nx, ny, nz;
	dot_t             ndot;
	logic [CNT_W-1:0] nidx;
	logic             emit;

	always_comb begin
		take = !have_q || ($signed(head.dot) > $signed(bdot_q));
		nx   = take ? head.x   : bx_q;
		ny   = take ? head.y   : by_q;
		nz   = take ? head.z   : bz_q;
		ndot = take ? head.dot : bdot_q;
		nidx = take ? cnt_q    : bidx_q;
		pop  = head_valid && (!head.last || !out_valid_q || out_ready);
		emit = pop && head.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				have_q <= !head.last;
				if (head.last) begin
					cnt_q <= '0;
				end else if (cnt_q == CNT_W'(MAX_POINTS - 1)) begin
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			bx_q   <= nx;
			by_q   <= ny;
			bz_q   <= nz;
			bdot_q <= ndot;
			bidx_q <= nidx;
		end
		if (emit) begin
			ox_q   <= nx;
			oy_q   <= ny;
			oz_q   <= nz;
			odot_q <= ndot;
			oidx_q <= IDX_W'(nidx);
		end
	end

	assign out_valid  = out_valid_q;
	assign best_x     = ox_q;
	assign best_y     = oy_q;
	assign best_z     = oz_q;
	assign best_dot   = odot_q;
	assign best_index = oidx_q;

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q && !have_q && cnt_q == '0)
		else $error("result beat did not clear the search");
	a_best_rises: assert property (@(posedge clk) disable iff (!arst_n)
		pop && have_q && !head.last |=> $signed(bdot_q) >= $signed($past(bdot_q)))
		else $error("running best dot went down inside a query");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !emit)
		else $error("pending result overwritten");

endmodule

FILE: rtl/transformed_support_point_search_unit.sv
// top level of the transformed support point search unit
//
// usage:
//  - cfg channel: cfg_index selects row x (0), row y (1), row z (2) or the
//    search direction (3); other indexes are dropped. cfg_ready is always
//    high. write only while the unit is idle
//  - in channel: one beat per vertex (q16.16 point, last_point flag); the
//    beat with last_point set closes the query
//  - out channel: one beat per query with the transformed winner, its
//    index in the set and its saturated dot value
// path: a last vertex that has nothing queued ahead of it passes the four
//   front stages, the first loaded on the accepting edge, then the queue
//   write, then the compare into the result register, and shows up on out_valid
// throughput: one vertex per cycle, set by the four-stage multiplier
//   pipeline of the front end; in_ready falls when front stages plus queue
//   entries reach the queue depth of eight
// reset: identity transform, direction +x, empty queue, no candidate,
//   no pending result
// receiver stall: the result register holds its beat; the back end keeps
//   folding non-last vertices and the queue absorbs the front end; in_ready
//   drops once front stages plus queue entries reach the queue depth
module transformed_support_point_search_unit import tssu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ROW_REG_W-1:0] cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  coord_t               point_x,
	input  coord_t               point_y,
	input  coord_t               point_z,
	input  logic                 last_point,
	output logic                 out_valid,
	input  logic                 out_ready,
	output coord_t               best_x,
	output coord_t               best_y,
	output coord_t               best_z,
	output logic [IDX_W-1:0]     best_index,
	output dot_t                 best_dot
);

	// configuration registers
	logic [2:0][ROW_REG_W-1:0] rows_q;
	logic [DIR_REG_W-1:0]      dir_q;

	// front to queue
	logic                 push;
	entry_t               push_entry;
	logic [FLY_W-1:0]     in_flight;

	// queue to back
	logic                 head_valid;
	entry_t               head;
	logic                 pop;
	logic [QCNT_W-1:0]    q_count;

	logic                 accept;
	logic [OCC_W-1:0]     occupancy;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q[0] <= ROW_X_RST;
			rows_q[1] <= ROW_Y_RST;
			rows_q[2] <= ROW_Z_RST;
			dir_q     <= DIR_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ROW_X:     rows_q[0] <= cfg_data;
				CFG_ROW_Y:     rows_q[1] <= cfg_data;
				CFG_ROW_Z:     rows_q[2] <= cfg_data;
				CFG_DIRECTION: dir_q     <= cfg_data[DIR_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// reserve a queue slot for every vertex in the front pipeline, so the
	// front never has to stall
	assign occupancy = OCC_W'(q_count) + OCC_W'(in_flight);
	assign in_ready  = occupancy < OCC_W'(QUEUE_DEPTH);
	assign accept    = in_valid && in_ready;

	tssu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.point_x    (point_x),
		.point_y    (point_y),
		.point_z    (point_z),
		.last_point (last_point),
		.rows       (rows_q),
		.direction  (dir_q),
		.push       (push),
		.push_entry (push_entry),
		.in_flight  (in_flight)
	);

	tssu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head),
		.count      (q_count)
	);

	tssu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.best_x     (best_x),
		.best_y     (best_y),
		.best_z     (best_z),
		.best_index (best_index),
		.best_dot   (best_dot)
	);

endmodule

FILE: dv/tb_transformed_support_point_search_unit.sv
// self-checking testbench for the transformed support point search unit
module tb_transformed_support_point_search_unit;
	import tssu_pkg::*;

	// cycles with no beat on any channel before the run is declared hung
	localparam int unsigned QUIET_LIMIT = 4000;
	// length of the forced receiver stall that backs the queue up
	localparam int unsigned HOLD_LONG   = 300;
	// wait after the last result so trailing vertices clear the pipeline
	localparam int unsigned SETTLE_CYCLES = 12;

	localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
	localparam coord_t COORD_MIN = 32'sh8000_0000;
	localparam coord_t ONE       = 32'sh0001_0000;
	localparam longint DOT_HI    = 64'sd140737488355327;
	localparam longint DOT_LO    = -64'sd140737488355328;
	// an index that selects no register
	localparam logic [CFG_IDX_W-1:0] CFG_NONE = CFG_IDX_W'(8'hA5);

	localparam logic [15:0] Q_MAX  = 16'h7FFF;
	localparam logic [15:0] Q_MIN  = 16'h8000;
	localparam logic [15:0] Q_ONE  = 16'h1000;
	localparam logic [15:0] Q_ZERO = 16'h0000;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		logic   closes;
	} vertex_t;

	typedef struct packed {
		coord_t           x;
		coord_t           y;
		coord_t           z;
		logic [IDX_W-1:0] index;
		dot_t             dot;
	} support_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ROW_REG_W-1:0] cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	coord_t               point_x = '0;
	coord_t               point_y = '0;
	coord_t               point_z = '0;
	logic                 last_point = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	coord_t               best_x;
	coord_t               best_y;
	coord_t               best_z;
	logic [IDX_W-1:0]     best_index;
	dot_t                 best_dot;

	transformed_support_point_search_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.point_x    (point_x),
		.point_y    (point_y),
		.point_z    (point_z),
		.last_point (last_point),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.best_x     (best_x),
		.best_y     (best_y),
		.best_z     (best_z),
		.best_index (best_index),
		.best_dot   (best_dot)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// vertices waiting to be offered, and winners the block still owes us
	vertex_t  vertex_feed[$];
	support_t winners_due[$];

	// shadow of the transform and direction registers
	logic [ROW_REG_W-1:0] cur_row_x = ROW_X_RST;
	logic [ROW_REG_W-1:0] cur_row_y = ROW_Y_RST;
	logic [ROW_REG_W-1:0] cur_row_z = ROW_Z_RST;
	logic [DIR_REG_W-1:0] cur_dir   = DIR_RST;

	// shadow of the running search
	dot_t             lead_dot = '0;
	coord_t           lead_x = '0;
	coord_t           lead_y = '0;
	coord_t           lead_z = '0;
	logic [IDX_W-1:0] lead_index = '0;
	logic [IDX_W-1:0] vertex_pos = '0;
	logic             lead_valid = 1'b0;

	// idling controls, set per phase by the sequencer
	logic        in_idle_on = 1'b1;
	logic        out_idle_on = 1'b1;
	logic        hold_request = 1'b0;
	int unsigned hold_left = 0;
	int unsigned feed_gap = 0;
	int unsigned ready_gap = 0;
	logic        vertex_taken = 1'b0;
	vertex_t     next_vertex;

	// bookkeeping
	int unsigned mismatches = 0;
	int unsigned vertices_sent = 0;
	int unsigned results_seen = 0;
	int unsigned reg_writes = 0;
	int unsigned quiet_cycles = 0;

	// one row of the affine transform: exact sum in q.28, floor to q16.16, clamp
	function automatic coord_t apply_row(logic [ROW_REG_W-1:0] row, coord_t px, coord_t py,
			coord_t pz);
		longint acc;
		acc = longint'($signed(row[15:0])) * longint'(px)
			+ longint'($signed(row[31:16])) * longint'(py)
			+ longint'($signed(row[47:32])) * longint'(pz)
			+ longint'($signed(row[63:48])) * 64'sd65536;
		// arithmetic shift floors toward minus infinity
		acc = acc >>> 12;
		if (acc > longint'(COORD_MAX)) return COORD_MAX;
		if (acc < longint'(COORD_MIN)) return COORD_MIN;
		return coord_t'(acc);
	endfunction

	// take one vertex into the running search, queue a winner when it closes the set
	function automatic void fold_vertex(coord_t px, coord_t py, coord_t pz, logic closes);
		coord_t   wx;
		coord_t   wy;
		coord_t   wz;
		longint   d;
		support_t win;
		wx = apply_row(cur_row_x, px, py, pz);
		wy = apply_row(cur_row_y, px, py, pz);
		wz = apply_row(cur_row_z, px, py, pz);
		d = longint'($signed(cur_dir[15:0])) * longint'(wx)
			+ longint'($signed(cur_dir[31:16])) * longint'(wy)
			+ longint'($signed(cur_dir[47:32])) * longint'(wz);
		if (d > DOT_HI) d = DOT_HI;
		else if (d < DOT_LO) d = DOT_LO;
		// strictly greater only, so a tie keeps the earlier vertex
		if (!lead_valid || d > longint'(lead_dot)) begin
			lead_dot   = dot_t'(d);
			lead_x     = wx;
			lead_y     = wy;
			lead_z     = wz;
			lead_index = vertex_pos;
			lead_valid = 1'b1;
		end
		// index wraps after MAX_POINTS vertices
		vertex_pos = vertex_pos + 1'b1;
		if (closes) begin
			win.x     = lead_x;
			win.y     = lead_y;
			win.z     = lead_z;
			win.index = lead_index;
			win.dot   = lead_dot;
			winners_due.push_back(win);
			lead_dot   = '0;
			lead_x     = '0;
			lead_y     = '0;
			lead_z     = '0;
			lead_index = '0;
			vertex_pos = '0;
			lead_valid = 1'b0;
		end
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int unsigned pick_gap(logic idle_on);
		int unsigned r;
		if (!idle_on) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// q4.12 coefficient: extremes, zero, identity, minus one, small and anything
	function automatic logic [15:0] rand_coef();
		case ($urandom_range(0, 9))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return Q_ZERO;
			3, 4: return Q_ONE;
			5: return 16'hF000;
			6, 7: return 16'($urandom_range(0, 16'h3FFF)) - 16'h2000;
			default: return 16'($urandom);
		endcase
	endfunction

	// q16.16 coordinate: extremes, zero, full range, or within +-128
	function automatic coord_t rand_coord();
		case ($urandom_range(0, 9))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2: return '0;
			3, 4: return coord_t'($urandom);
			default: return coord_t'($urandom_range(0, 24'hFF_FFFF) - 32'h0080_0000);
		endcase
	endfunction

	function automatic logic [ROW_REG_W-1:0] pack_row(logic [15:0] m0, logic [15:0] m1,
			logic [15:0] m2, logic [15:0] t);
		return {t, m2, m1, m0};
	endfunction

	task automatic push_vertex(coord_t px, coord_t py, coord_t pz, logic closes);
		vertex_t v;
		v.x      = px;
		v.y      = py;
		v.z      = pz;
		v.closes = closes;
		vertex_feed.push_back(v);
	endtask

	// one register write beat; returns at a rising edge with the channel quiet
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ROW_REG_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_ROW_X: cur_row_x = data;
			CFG_ROW_Y: cur_row_y = data;
			CFG_ROW_Z: cur_row_z = data;
			CFG_DIRECTION: cur_dir = data[DIR_REG_W-1:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait until every vertex is in, every winner is out and the pipeline is empty
	task automatic settle_queries();
		while (vertex_feed.size() != 0 || in_valid) @(posedge clk);
		while (winners_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// random sets, the last one of the budget always closed so the phase ends idle
	task automatic random_queries(int unsigned budget, logic short_sets);
		int unsigned sent;
		int unsigned set_len;
		coord_t      px;
		coord_t      py;
		coord_t      pz;
		sent = 0;
		px = '0;
		py = '0;
		pz = '0;
		while (sent < budget) begin
			if (short_sets) set_len = $urandom_range(1, 3);
			else if ($urandom_range(0, 9) == 0) set_len = $urandom_range(13, 40);
			else set_len = $urandom_range(1, 6);
			for (int unsigned k = 0; k < set_len; k++) begin
				// sometimes repeat the previous vertex to force a tie
				if (k == 0 || $urandom_range(0, 6) != 0) begin
					px = rand_coord();
					py = rand_coord();
					pz = rand_coord();
				end
				push_vertex(px, py, pz, k == set_len - 1);
				sent++;
			end
		end
	endtask

	// input driver: new beat only once the current one is taken
	always @(negedge clk) begin
		if (arst_n && (!in_valid || vertex_taken)) begin
			vertex_taken = 1'b0;
			if (feed_gap > 0) begin
				feed_gap--;
				in_valid <= 1'b0;
			end else if (vertex_feed.size() != 0) begin
				next_vertex = vertex_feed.pop_front();
				point_x    <= next_vertex.x;
				point_y    <= next_vertex.y;
				point_z    <= next_vertex.z;
				last_point <= next_vertex.closes;
				in_valid   <= 1'b1;
				feed_gap = pick_gap(in_idle_on);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random back-pressure plus the one long forced stall
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_request) begin
				hold_left = HOLD_LONG;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (ready_gap > 0) begin
				ready_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				ready_gap = pick_gap(out_idle_on);
			end
		end
	end

	// input beats feed the predictor in acceptance order
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			fold_vertex(point_x, point_y, point_z, last_point);
			vertices_sent++;
			vertex_taken = 1'b1;
		end
	end

	// result beats are matched against the oldest owed winner
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (winners_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: x=%h y=%h z=%h index=%0d dot=%h",
						best_x, best_y, best_z, best_index, best_dot);
			end else begin
				if (best_x !== winners_due[0].x || best_y !== winners_due[0].y
						|| best_z !== winners_due[0].z || best_index !== winners_due[0].index
						|| best_dot !== winners_due[0].dot) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("result %0d mismatch, expected x=%h y=%h z=%h index=%0d dot=%h",
							results_seen, winners_due[0].x, winners_due[0].y, winners_due[0].z,
							winners_due[0].index, winners_due[0].dot);
						$display("  got x=%h y=%h z=%h index=%0d dot=%h",
							best_x, best_y, best_z, best_index, best_dot);
					end
				end
				void'(winners_due.pop_front());
			end
		end
	end

	// watchdog on channel activity
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no beat for %0d cycles, %0d winners still owed",
					quiet_cycles, winners_due.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset transform is identity with direction +x, so dot follows x alone
		// single vertex set
		push_vertex('0, '0, '0, 1'b1);
		// tie on dot: first of the equal vertices wins, y tells them apart
		push_vertex(ONE, 2 * ONE, '0, 1'b0);
		push_vertex(ONE, 3 * ONE, '0, 1'b0);
		push_vertex(ONE >>> 1, '0, ONE, 1'b1);
		// all dots negative: first vertex is taken regardless, then beaten
		push_vertex(-3 * ONE, '0, '0, 1'b0);
		push_vertex(-1 * ONE, ONE, '0, 1'b0);
		push_vertex(-2 * ONE, '0, '0, 1'b1);
		// coordinate extremes pass straight through
		push_vertex(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
		push_vertex(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
		settle_queries();

		// extreme coefficients: every row and the dot saturate both ways
		write_reg(CFG_ROW_X, pack_row(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
		write_reg(CFG_ROW_Y, pack_row(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
		write_reg(CFG_ROW_Z, pack_row(Q_ZERO, Q_MAX, Q_ZERO, Q_MIN));
		write_reg(CFG_DIRECTION, {16'hFFFF, Q_MAX, Q_MIN, Q_MAX});
		// a write to an unmapped index must change nothing
		write_reg(CFG_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
		push_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
		push_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
		push_vertex('0, '0, '0, 1'b0);
		push_vertex(COORD_MAX, COORD_MIN, '0, 1'b1);
		push_vertex(ONE, -ONE, ONE, 1'b1);
		settle_queries();

		// zero direction: every dot ties at zero, index 0 must win
		write_reg(CFG_DIRECTION, '0);
		write_reg(CFG_ROW_X, '0);
		for (int i = 0; i < 4; i++) push_vertex(rand_coord(), rand_coord(), rand_coord(), i == 3);
		settle_queries();

		// one set longer than the index range so the counter wraps
		write_reg(CFG_ROW_X, pack_row(Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO));
		write_reg(CFG_ROW_Y, pack_row(Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO));
		write_reg(CFG_ROW_Z, pack_row(Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO));
		write_reg(CFG_DIRECTION, {Q_ZERO, Q_ZERO, Q_ONE});
		for (int i = 0; i < 1040; i++) begin
			if (i == 1030 || i == 1035)
				push_vertex(COORD_MAX, coord_t'(i), '0, i == 1039);
			else
				push_vertex(coord_t'($urandom_range(0, 32'h03FF_FFFF)), coord_t'(i), '0,
					i == 1039);
		end
		settle_queries();

		// random configurations with random sets
		for (int ph = 0; ph < 6; ph++) begin
			// one phase runs with no idling on either side
			in_idle_on  = (ph != 1);
			out_idle_on = (ph != 1);
			write_reg(CFG_ROW_X, pack_row(rand_coef(), rand_coef(), rand_coef(), rand_coef()));
			write_reg(CFG_ROW_Y, pack_row(rand_coef(), rand_coef(), rand_coef(), rand_coef()));
			write_reg(CFG_ROW_Z, pack_row(rand_coef(), rand_coef(), rand_coef(), rand_coef()));
			write_reg(CFG_DIRECTION, {16'h0, rand_coef(), rand_coef(), rand_coef()});
			random_queries(80, 1'b0);
			settle_queries();
		end

		// back-pressure: receiver holds off while many short sets stream in
		in_idle_on  = 1'b0;
		out_idle_on = 1'b1;
		hold_request = 1'b1;
		random_queries(60, 1'b1);
		settle_queries();

		$display("run covered %0d vertices, %0d winners checked, %0d register writes",
			vertices_sent, results_seen, reg_writes);
		$display("including saturation, ties, index wrap and a %0d-cycle receiver stall",
			HOLD_LONG);
		if (mismatches == 0 && winners_due.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d winners never seen", mismatches, winners_due.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
